// ----- hw/rtl/anti_replay_window_check_top_defines.svh -----
// Assertion macros for the anti-replay window check.
`ifndef ANTI_REPLAY_WINDOW_CHECK_TOP_DEFINES_SVH
`define ANTI_REPLAY_WINDOW_CHECK_TOP_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define ARW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define ARW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/arw_pkg.sv -----
// Types and constants shared by the anti-replay window check.
package arw_pkg;

  localparam int NONCE_W  = 64;
  localparam int OFF_W    = 6;
  localparam int ROW_BITS = 64;
  localparam int TAG_W    = NONCE_W - OFF_W;

  typedef enum logic [2:0] {
    RSN_NEW_HIGH  = 3'd0,
    RSN_IN_WINDOW = 3'd1,
    RSN_EQUAL     = 3'd2,
    RSN_TOO_OLD   = 3'd3,
    RSN_SEEN      = 3'd4
  } reason_t;

  // One bitmap row: the 64-nonce block it holds and a seen flag per nonce.
  typedef struct packed {
    logic [TAG_W-1:0]    tag;
    logic [ROW_BITS-1:0] bits;
  } row_t;

  localparam logic [ROW_BITS-1:0] ROW_ONE = ROW_BITS'(1);

  // Unwritten rows stand for block zero with nonce zero marked.
  localparam row_t ROW_RST = '{tag: '0, bits: ROW_ONE};

endpackage

// ----- hw/rtl/arw_if.sv -----
// Valid/ready channel interfaces for nonces and check results.
interface arw_in_if;
  logic                        valid;
  logic                        ready;
  logic [arw_pkg::NONCE_W-1:0] nonce;

  modport source (output valid, output nonce, input ready);
  modport sink   (input valid, input nonce, output ready);
endinterface

interface arw_out_if;
  logic             valid;
  logic             ready;
  logic             accepted;
  arw_pkg::reason_t reason;

  modport source (output valid, output accepted, output reason, input ready);
  modport sink   (input valid, input accepted, input reason, output ready);
endinterface

// ----- hw/rtl/arw_row_ram.sv -----
// Ring of bitmap rows: one write port, one registered read port, per-row valid flags.
module arw_row_ram #(
  parameter int ROWS  = 16,
  parameter int IDX_W = $clog2(ROWS)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rd_en,
  input  logic [IDX_W-1:0]  rd_idx,
  output arw_pkg::row_t     rd_row,
  input  logic              wr_en,
  input  logic [IDX_W-1:0]  wr_idx,
  input  arw_pkg::row_t     wr_row
);

  arw_pkg::row_t mem [ROWS];
  arw_pkg::row_t rd_data_r;
  logic          rd_vld_r;
  logic [ROWS-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_idx] <= wr_row;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_idx] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_r <= vld_r[rd_idx];
      end
    end
  end

  assign rd_row = rd_vld_r ? rd_data_r : arw_pkg::ROW_RST;

endmodule

// ----- hw/rtl/anti_replay_window_check_top.sv -----
// Anti-replay sliding-window check: top level with check stage and result register.
//
//   channel | dir | handshake            | payload
//   in_ch   | in  | valid/ready          | nonce[63:0]
//   out_ch  | out | valid/ready          | accepted, reason[2:0]
//
// One nonce per cycle sustained while out_ch takes each result.
// The row RAM read issued on acceptance feeds the check stage the next cycle;
// a write to the same row by the item ahead is forwarded.
// Reset zeroes the highest nonce and clears the row valid flags.
// A result held on out_ch stalls the check stage, then in_ch.
`include "anti_replay_window_check_top_defines.svh"

module anti_replay_window_check_top #(
  parameter int WINDOW_BITS = 512
) (
  input  logic     clk,
  input  logic     rst_n,
  arw_in_if.sink   in_ch,
  arw_out_if.source out_ch
);

  localparam int ROWS  = 2 ** $clog2(WINDOW_BITS / arw_pkg::ROW_BITS + 2);
  localparam int IDX_W = $clog2(ROWS);

  logic                        s1_v_r;
  logic [arw_pkg::NONCE_W-1:0] s1_nonce_r;
  logic [arw_pkg::NONCE_W-1:0] h_r;
  logic                        out_v_r;
  logic                        out_acc_r;
  arw_pkg::reason_t            out_rsn_r;
  logic                        fwd_v_r;
  logic [IDX_W-1:0]            fwd_idx_r;
  arw_pkg::row_t               fwd_row_r;

  logic                        in_acc;
  logic                        s1_adv;
  logic [IDX_W-1:0]            in_idx;
  logic [arw_pkg::TAG_W-1:0]   s1_blk;
  logic [IDX_W-1:0]            s1_idx;
  logic [arw_pkg::OFF_W-1:0]   s1_off;
  arw_pkg::row_t               rd_row;
  arw_pkg::row_t               cur_row;
  logic                        tag_hit;
  logic                        seen;
  logic                        is_new;
  logic [arw_pkg::NONCE_W-1:0] diff;
  logic                        out_acc_nxt;
  arw_pkg::reason_t            out_rsn_nxt;
  logic                        wr_en;
  arw_pkg::row_t               wr_row;

  assign s1_adv       = s1_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready  = !s1_v_r || s1_adv;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign in_idx       = in_ch.nonce[arw_pkg::OFF_W +: IDX_W];

  assign s1_blk = s1_nonce_r[arw_pkg::NONCE_W-1:arw_pkg::OFF_W];
  assign s1_idx = s1_blk[IDX_W-1:0];
  assign s1_off = s1_nonce_r[arw_pkg::OFF_W-1:0];

  arw_row_ram #(
    .ROWS  (ROWS),
    .IDX_W (IDX_W)
  ) u_rows (
    .clk    (clk),
    .rst_n  (rst_n),
    .rd_en  (in_acc),
    .rd_idx (in_idx),
    .rd_row (rd_row),
    .wr_en  (wr_en),
    .wr_idx (s1_idx),
    .wr_row (wr_row)
  );

  assign cur_row = (fwd_v_r && fwd_idx_r == s1_idx) ? fwd_row_r : rd_row;
  assign tag_hit = cur_row.tag == s1_blk;
  assign seen    = tag_hit && cur_row.bits[s1_off];
  assign is_new  = s1_nonce_r > h_r;
  assign diff    = h_r - s1_nonce_r;

  always_comb begin
    if (is_new) begin
      out_acc_nxt = 1'b1;
      out_rsn_nxt = arw_pkg::RSN_NEW_HIGH;
    end else if (diff == '0) begin
      out_acc_nxt = 1'b0;
      out_rsn_nxt = arw_pkg::RSN_EQUAL;
    end else if (diff > arw_pkg::NONCE_W'(WINDOW_BITS)) begin
      out_acc_nxt = 1'b0;
      out_rsn_nxt = arw_pkg::RSN_TOO_OLD;
    end else if (seen) begin
      out_acc_nxt = 1'b0;
      out_rsn_nxt = arw_pkg::RSN_SEEN;
    end else begin
      out_acc_nxt = 1'b1;
      out_rsn_nxt = arw_pkg::RSN_IN_WINDOW;
    end
  end

  // A stale tag means the row held an older block that has left the window.
  assign wr_en       = s1_adv && out_acc_nxt;
  assign wr_row.tag  = s1_blk;
  assign wr_row.bits = (tag_hit ? cur_row.bits : '0) | (arw_pkg::ROW_ONE << s1_off);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      fwd_v_r <= 1'b0;
      h_r     <= '0;
    end else begin
      if (in_ch.ready) begin
        s1_v_r <= in_ch.valid;
      end
      if (in_acc) begin
        fwd_v_r <= wr_en;
      end
      if (s1_adv) begin
        out_v_r <= 1'b1;
        if (is_new) begin
          h_r <= s1_nonce_r;
        end
      end else if (out_ch.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_nonce_r <= in_ch.nonce;
      fwd_idx_r  <= s1_idx;
      fwd_row_r  <= wr_row;
    end
    if (s1_adv) begin
      out_acc_r <= out_acc_nxt;
      out_rsn_r <= out_rsn_nxt;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.accepted = out_acc_r;
  assign out_ch.reason   = out_rsn_r;

  `ARW_ASSERT_IMP(a_acc_matches_rsn, out_v_r, out_acc_r == (out_rsn_r == arw_pkg::RSN_NEW_HIGH || out_rsn_r == arw_pkg::RSN_IN_WINDOW), "accepted flag disagrees with reason")
  `ARW_ASSERT_NXT(a_new_high_taken, s1_adv && is_new, h_r == $past(s1_nonce_r), "highest nonce not updated")
  `ARW_ASSERT_IMP(a_stall_blocks_in, s1_v_r && out_v_r && !out_ch.ready, !in_ch.ready, "input taken while check stage stalled")
  `ARW_ASSERT_IMP(a_reject_no_write, s1_adv && !out_acc_nxt, !wr_en, "rejected nonce wrote the bitmap")

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the anti-replay sliding-window check.
module testbench;

  localparam int WINDOW_BITS = 512;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1020;
  localparam int HOLD_AFTER = 300;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic             accepted;
    arw_pkg::reason_t reason;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  arw_in_if  in_bus ();
  arw_out_if out_bus ();

  anti_replay_window_check_top #(.WINDOW_BITS(WINDOW_BITS)) uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_bus),
    .out_ch (out_bus)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [arw_pkg::NONCE_W-1:0] window_top = '0;
  logic [WINDOW_BITS-1:0]      seen_map = '0;
  logic [arw_pkg::NONCE_W-1:0] pending_nonces[$];
  verdict_t                    expected_verdicts[$];
  logic [arw_pkg::NONCE_W-1:0] recent_nonces[$];
  logic [arw_pkg::NONCE_W-1:0] gen_top = '0;

  int  mismatches = 0;
  int  result_count = 0;
  int  cycle_count = 0;
  logic in_took = 1'b0;

  int  burst_left = 0;
  int  gap_left = 0;
  logic offer;

  int  rx_phase = 0;
  int  hold_left = 0;
  logic hold_done = 1'b0;
  logic take;

  // Mirror of the window: highest accepted nonce plus one seen flag per older nonce in the window.
  function automatic verdict_t check_nonce(input logic [arw_pkg::NONCE_W-1:0] nonce);
    logic [arw_pkg::NONCE_W-1:0] delta;
    verdict_t v;
    if (nonce > window_top) begin
      delta = nonce - window_top;
      if (delta > 64'(WINDOW_BITS)) begin
        seen_map = '0;
      end else begin
        seen_map = seen_map << delta;
        seen_map[delta - 1] = 1'b1;
      end
      window_top = nonce;
      v.accepted = 1'b1;
      v.reason = arw_pkg::RSN_NEW_HIGH;
    end else begin
      delta = window_top - nonce;
      v.accepted = 1'b0;
      if (delta == '0) begin
        v.reason = arw_pkg::RSN_EQUAL;
      end else if (delta > 64'(WINDOW_BITS)) begin
        v.reason = arw_pkg::RSN_TOO_OLD;
      end else if (seen_map[delta - 1]) begin
        v.reason = arw_pkg::RSN_SEEN;
      end else begin
        seen_map[delta - 1] = 1'b1;
        v.accepted = 1'b1;
        v.reason = arw_pkg::RSN_IN_WINDOW;
      end
    end
    return v;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  task automatic queue_nonce(input logic [arw_pkg::NONCE_W-1:0] nonce);
    pending_nonces.push_back(nonce);
    if (nonce > gen_top) gen_top = nonce;
    recent_nonces.push_back(nonce);
    if (recent_nonces.size() > 32) void'(recent_nonces.pop_front());
  endtask

  // Monitor: predict on input transactions, check on result transactions.
  always @(posedge clk) begin
    verdict_t want;
    in_took <= rst_n && in_bus.valid && in_bus.ready;
    if (rst_n) begin
      if (in_bus.valid && in_bus.ready)
        expected_verdicts.push_back(check_nonce(in_bus.nonce));
      if (out_bus.valid && out_bus.ready) begin
        result_count++;
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("unexpected result accepted=%0b reason=%0d",
                                    out_bus.accepted, out_bus.reason));
        end else begin
          want = expected_verdicts.pop_front();
          if (out_bus.accepted !== want.accepted)
            report_mismatch($sformatf("accepted %0b, expected %0b",
                                      out_bus.accepted, want.accepted));
          if (out_bus.reason !== want.reason)
            report_mismatch($sformatf("reason %0d, expected %0d",
                                      out_bus.reason, want.reason));
        end
      end
    end
  end

  // Sender: bursts of transactions with random gaps in between.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
      in_bus.nonce <= '0;
    end else begin
      if (in_took) void'(pending_nonces.pop_front());
      if (!in_bus.valid || in_took) begin
        offer = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_nonces.size() > 0) begin
          offer = 1'b1;
          if (burst_left == 0) burst_left = $urandom_range(1, 40);
          burst_left--;
          if (burst_left == 0) begin
            case ($urandom_range(0, 9))
              0, 1, 2, 3, 4: gap_left = 0;
              5, 6, 7, 8:    gap_left = $urandom_range(1, 4);
              default:       gap_left = $urandom_range(5, 20);
            endcase
          end
        end
        in_bus.valid <= offer;
        if (offer) in_bus.nonce <= pending_nonces[0];
      end
    end
  end

  // Receiver: stall pattern rotates through four modes, plus one long hold-off.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      rx_phase++;
      if (!hold_done && result_count >= HOLD_AFTER) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        take = 1'b0;
      end else begin
        case ((rx_phase >> 8) % 4)
          0:       take = 1'b1;
          1:       take = ($urandom_range(0, 9) < 7);
          2:       take = (rx_phase % 5 != 0);
          default: take = ($urandom_range(0, 9) < 3);
        endcase
      end
      out_bus.ready <= take;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    logic [arw_pkg::NONCE_W-1:0] pick;
    int sel;
    int off;

    // directed: zero at reset, exact window jump, a jump past the window, edges
    queue_nonce(64'd0);
    queue_nonce(64'd1);
    queue_nonce(64'd1);
    queue_nonce(64'd0);
    queue_nonce(64'd513);
    queue_nonce(64'd1);
    queue_nonce(64'd0);
    queue_nonce(64'd100);
    queue_nonce(64'd100);
    queue_nonce(64'd1113);
    queue_nonce(64'd600);
    queue_nonce(64'd601);
    queue_nonce(64'd1112);
    queue_nonce(64'd1113);
    queue_nonce(64'd1100);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      sel = $urandom_range(0, 99);
      if (i == RANDOM_ITEMS / 2) begin
        pick = {2'b01, 30'($urandom), 32'($urandom)};
      end else if (sel < 35) begin
        pick = gen_top + 64'($urandom_range(1, 16));
      end else if (sel < 45) begin
        pick = gen_top + 64'($urandom_range(500, 530));
      end else if (sel < 48) begin
        pick = gen_top + 64'($urandom_range(531, 100000));
      end else if (sel < 75) begin
        off = $urandom_range(0, 520);
        pick = (gen_top >= 64'(off)) ? gen_top - 64'(off) : gen_top;
      end else if (sel < 88) begin
        pick = recent_nonces[$urandom_range(0, recent_nonces.size() - 1)];
      end else begin
        pick = (gen_top != '0) ? {$urandom, $urandom} % gen_top : '0;
      end
      queue_nonce(pick);
    end

    // top of the nonce range
    queue_nonce('1);
    queue_nonce(64'hFFFF_FFFF_FFFF_FFFE);
    queue_nonce('1);
    queue_nonce(64'hFFFF_FFFF_FFFF_FFFF - 64'd512);
    queue_nonce(64'hFFFF_FFFF_FFFF_FFFF - 64'd513);
    queue_nonce(64'hFFFF_FFFF_FFFF_FFFE);
    queue_nonce(64'd0);

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (pending_nonces.size() > 0) @(negedge clk);
    while (expected_verdicts.size() > 0) @(negedge clk);
    repeat (10) @(negedge clk);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+hw/rtl
hw/rtl/arw_pkg.sv
hw/rtl/arw_if.sv
hw/rtl/arw_row_ram.sv
hw/rtl/anti_replay_window_check_top.sv
tb/testbench.sv
